// ===== rtl/core/dsq_pkg.sv =====
// shared types and constants of the delta sleep queue
package dsq_pkg;

  localparam int unsigned MAX_SLEEPERS_DEF = 16;
  localparam int unsigned ID_W = 8;
  localparam int unsigned TICK_W = 32;

  localparam logic EV_READY = 1'b0;
  localparam logic EV_DROP = 1'b1;

  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_RELEASE,
    OP_SLEEP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   thread_id;
    logic [TICK_W-1:0] ticks;
  } cmd_t;

  typedef struct packed {
    logic            event_code;
    logic [ID_W-1:0] ready_thread;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] delta;
  } ent_t;

endpackage

// ===== rtl/core/dsq_ram.sv =====
// generic single write port ram with registered read
module dsq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dsq_fifo.sv =====
// small first-in first-out queue of packed words
module dsq_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/dsq_front.sv =====
// front end: accepts items, classifies them and queues commands
module dsq_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              kind_i,
  input  logic [dsq_pkg::ID_W-1:0]          thread_id_i,
  input  logic [dsq_pkg::TICK_W-1:0]        sleep_ticks_i,
  output logic                              cmd_valid_o,
  output dsq_pkg::cmd_t                     cmd_o,
  input  logic                              cmd_pop_i
);

  import dsq_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.thread_id = thread_id_i;
    cmd_in.ticks     = sleep_ticks_i;
    if (kind_i == KIND_TICK) begin
      cmd_in.op = OP_TICK;
    end else if (sleep_ticks_i == '0) begin
      cmd_in.op = OP_RELEASE;
    end else begin
      cmd_in.op = OP_SLEEP;
    end
  end

  dsq_fifo #(
    .Width($bits(cmd_t)),
    .Depth(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop_i),
    .rdata_o(cmd_o),
    .empty_o(cmd_empty)
  );

  assign cmd_valid_o = ~cmd_empty;

endmodule

// ===== rtl/core/dsq_back.sv =====
// back end: delta list sequencer over a circular ram
module dsq_back #(
  parameter int unsigned MaxSleepers = dsq_pkg::MAX_SLEEPERS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  dsq_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_valid_o,
  output dsq_pkg::res_t res_o
);

  import dsq_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSleepers);
  localparam int unsigned CntW = $clog2(MaxSleepers + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRD   = 3'd1;
  localparam logic [2:0] S_TRUN  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_INS   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   sidx_q, sidx_d;
  logic [CntW-1:0]   n_q, n_d;
  logic              rpend_q, rpend_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [ID_W-1:0]   id_q, id_d;

  logic            re, we;
  logic [CntW-1:0] rl, wl;
  ent_t            wdata, rd;
  logic [$bits(ent_t)-1:0] ram_rdata;
  logic [CntW-1:0] n_nxt, pos_nxt;

  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] l);
    logic [CntW:0] s;
    s = (CntW+1)'(head) + (CntW+1)'(l);
    if (s >= (CntW+1)'(MaxSleepers)) begin
      s = s - (CntW+1)'(MaxSleepers);
    end
    return s[IdxW-1:0];
  endfunction

  assign rd      = ent_t'(ram_rdata);
  assign n_nxt   = n_q + CntW'(1);
  assign pos_nxt = pos_q + CntW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    pos_d       = pos_q;
    sidx_d      = sidx_q;
    n_d         = n_q;
    rpend_d     = rpend_q;
    rem_d       = rem_q;
    id_d        = id_q;
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    re          = 1'b0;
    rl          = '0;
    we          = 1'b0;
    wl          = '0;
    wdata       = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_TICK: begin
              cmd_pop_o = 1'b1;
              if (count_q != '0) begin
                re      = 1'b1;
                state_d = S_TRD;
              end
            end
            OP_RELEASE: begin
              if (!res_full_i) begin
                cmd_pop_o   = 1'b1;
                res_valid_o = 1'b1;
                res_o       = '{event_code: EV_READY, ready_thread: cmd_i.thread_id,
                                last: 1'b1};
              end
            end
            OP_SLEEP: begin
              if (count_q == CntW'(MaxSleepers)) begin
                if (!res_full_i) begin
                  cmd_pop_o   = 1'b1;
                  res_valid_o = 1'b1;
                  res_o       = '{event_code: EV_DROP, ready_thread: cmd_i.thread_id,
                                  last: 1'b1};
                end
              end else begin
                cmd_pop_o = 1'b1;
                id_d      = cmd_i.thread_id;
                rem_d     = cmd_i.ticks;
                pos_d     = '0;
                if (count_q == '0) begin
                  state_d = S_INS;
                end else begin
                  re      = 1'b1;
                  state_d = S_WALK;
                end
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_TRD: begin
        if (rd.delta > TICK_W'(1)) begin
          we      = 1'b1;
          wdata   = '{id: rd.id, delta: rd.delta - TICK_W'(1)};
          state_d = S_IDLE;
        end else begin
          id_d    = rd.id;
          n_d     = CntW'(1);
          rpend_d = 1'b0;
          if (count_q > CntW'(1)) begin
            re      = 1'b1;
            rl      = CntW'(1);
            rpend_d = 1'b1;
          end
          state_d = S_TRUN;
        end
      end
      S_TRUN: begin
        if (!res_full_i) begin
          res_valid_o = 1'b1;
          if (rpend_q && rd.delta == '0) begin
            res_o   = '{event_code: EV_READY, ready_thread: id_q, last: 1'b0};
            id_d    = rd.id;
            n_d     = n_nxt;
            rpend_d = 1'b0;
            if (n_nxt < count_q) begin
              re      = 1'b1;
              rl      = n_nxt;
              rpend_d = 1'b1;
            end
          end else begin
            res_o   = '{event_code: EV_READY, ready_thread: id_q, last: 1'b1};
            head_d  = phys(head_q, n_q);
            count_d = count_q - n_q;
            state_d = S_IDLE;
          end
        end
      end
      S_WALK: begin
        if (rem_q >= rd.delta) begin
          rem_d = rem_q - rd.delta;
          pos_d = pos_nxt;
          if (pos_nxt < count_q) begin
            re = 1'b1;
            rl = pos_nxt;
          end else begin
            state_d = S_INS;
          end
        end else begin
          re      = 1'b1;
          rl      = count_q - CntW'(1);
          sidx_d  = count_q - CntW'(1);
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        wl    = sidx_q + CntW'(1);
        wdata = rd;
        if (sidx_q == pos_q) begin
          wdata.delta = rd.delta - rem_q;
          state_d     = S_INS;
        end else begin
          re     = 1'b1;
          rl     = sidx_q - CntW'(1);
          sidx_d = sidx_q - CntW'(1);
        end
      end
      S_INS: begin
        we      = 1'b1;
        wl      = pos_q;
        wdata   = '{id: id_q, delta: rem_q};
        count_d = count_q + CntW'(1);
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      rpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      rpend_q <= rpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    sidx_q <= sidx_d;
    n_q    <= n_d;
    rem_q  <= rem_d;
    id_q   <= id_d;
  end

  dsq_ram #(
    .Width($bits(ent_t)),
    .Depth(MaxSleepers)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(phys(head_q, wl)),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(phys(head_q, rl)),
    .rdata_o(ram_rdata)
  );

endmodule

// ===== rtl/core/delta_sleep_queue.sv =====
// top level of the delta list sleep queue
// sleep request: walk the list, shift the tail, write; ram has a read and a write port
// tick: decrement head or release expired threads; zero-tick request or drop: one result
// one command runs at a time in the back end; two-entry queues on input and result sides
// reset: asynchronous, active low; clears the list count, head and both queues
module delta_sleep_queue #(
  parameter int unsigned MaxSleepers = dsq_pkg::MAX_SLEEPERS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       kind_i,
  input  logic [dsq_pkg::ID_W-1:0]   thread_id_i,
  input  logic [dsq_pkg::TICK_W-1:0] sleep_ticks_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       event_code_o,
  output logic [dsq_pkg::ID_W-1:0]   ready_thread_o,
  output logic                       last_o
);

  import dsq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res, res_head;
  logic res_valid, res_full;

  dsq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .thread_id_i  (thread_id_i),
    .sleep_ticks_i(sleep_ticks_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  dsq_back #(
    .MaxSleepers(MaxSleepers)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  dsq_fifo #(
    .Width($bits(res_t)),
    .Depth(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_head),
    .empty_o(empty)
  );

  assign event_code_o   = res_head.event_code;
  assign ready_thread_o = res_head.ready_thread;
  assign last_o         = res_head.last;

endmodule

// ===== rtl/core/dsq_checker.sv =====
// port-level checks of the delta sleep queue and their binding
module dsq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic                       kind_i,
  input logic [dsq_pkg::ID_W-1:0]   thread_id_i,
  input logic [dsq_pkg::TICK_W-1:0] sleep_ticks_i,
  input logic                       empty,
  input logic                       pop,
  input logic                       event_code_o,
  input logic [dsq_pkg::ID_W-1:0]   ready_thread_o,
  input logic                       last_o
);

  import dsq_pkg::*;

  logic [31:0] open_q;
  logic        in_acc, last_acc;

  assign in_acc   = push & ~full;
  assign last_acc = pop & ~empty & last_o;

  // items taken in whose final result has not yet left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !last_acc) begin
      open_q <= open_q + 32'd1;
    end else if (last_acc && !in_acc) begin
      open_q <= open_q - 32'd1;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable({event_code_o, ready_thread_o, last_o})))
    else $error("result changed while waiting");

  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_code_o == EV_DROP) |-> last_o)
    else $error("dropped request without last");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (open_q != '0))
    else $error("result with no open item");

  // command queue, then back end into the result queue, which registers the released thread
  a_sleep_thread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_SLEEP && sleep_ticks_i == '0 && empty && open_q == '0)
    |=> ##1 (!empty && ready_thread_o == $past(thread_id_i, 2) && event_code_o == EV_READY))
    else $error("zero-tick request not released in time");

endmodule

bind delta_sleep_queue dsq_checker u_dsq_checker (.*);
